FILE: sv/tdsl_pkg.sv
// Shared constants, types and codes for the trajectory decimator with sync lookup.
package tdsl_pkg;

  localparam int COORD_W    = 24;
  localparam int SPEED_W    = 16;
  localparam int TIME_W     = 32;
  localparam int SYNC_W     = 10;
  localparam int DIST_W     = 16;
  localparam int CHUNK_W    = 7;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam int DEF_ROUTE_DEPTH = 1024;

  // Magnitude of one axis difference after saturation, its square and the 3-axis sum.
  localparam int SAT_W = 17;
  localparam int SQ_W  = 33;
  localparam int D2_W  = 35;
  localparam logic [SAT_W-1:0] AXIS_SAT = 17'h10000;

  localparam logic [DIST_W-1:0]  KEEP_DIST_RESET  = 16'd1000;
  localparam logic [DIST_W-1:0]  END_DIST_RESET   = 16'd10;
  localparam logic [CHUNK_W-1:0] CHUNK_SIZE_RESET = 7'd20;

  // Item operations.
  localparam logic OP_POINT = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    REG_KEEP_DIST  = 2'd0,
    REG_END_DIST   = 2'd1,
    REG_CHUNK_SIZE = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_FLUSH = 2'd1,
    KIND_SYNC  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPND,
    ST_MUL,
    ST_ACC,
    ST_DECIDE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    STEP_KEEP,
    STEP_END,
    STEP_DX,
    STEP_DY,
    STEP_DZ
  } step_t;

endpackage

FILE: sv/tdsl_if.sv
// Valid/ready channel interfaces for trajectory items and for results.
interface tdsl_item_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 op;
  logic signed [tdsl_pkg::COORD_W-1:0]  x_mm;
  logic signed [tdsl_pkg::COORD_W-1:0]  y_mm;
  logic signed [tdsl_pkg::COORD_W-1:0]  z_mm;
  logic signed [tdsl_pkg::SPEED_W-1:0]  speed_mm_s;
  logic        [tdsl_pkg::TIME_W-1:0]   time_ms;
  logic                                 first_point;
  logic                                 last_point;
  logic        [tdsl_pkg::TIME_W-1:0]   query_time_ms;

  modport source (output valid, op, x_mm, y_mm, z_mm, speed_mm_s, time_ms, first_point,
                  last_point, query_time_ms, input ready);
  modport sink (input valid, op, x_mm, y_mm, z_mm, speed_mm_s, time_ms, first_point,
                last_point, query_time_ms, output ready);
endinterface

interface tdsl_result_if;
  logic                                 valid;
  logic                                 ready;
  logic        [1:0]                    kind;
  logic signed [tdsl_pkg::COORD_W-1:0]  out_x_mm;
  logic signed [tdsl_pkg::COORD_W-1:0]  out_y_mm;
  logic signed [tdsl_pkg::SPEED_W-1:0]  out_speed_mm_s;
  logic        [tdsl_pkg::TIME_W-1:0]   out_time_ms;
  logic                                 chunk_end;
  logic                                 replace_route;
  logic                                 route_full;
  logic        [tdsl_pkg::SYNC_W-1:0]   sync_index;

  modport source (output valid, kind, out_x_mm, out_y_mm, out_speed_mm_s, out_time_ms,
                  chunk_end, replace_route, route_full, sync_index, input ready);
  modport sink (input valid, kind, out_x_mm, out_y_mm, out_speed_mm_s, out_time_ms,
                chunk_end, replace_route, route_full, sync_index, output ready);
endinterface

FILE: sv/trajectory_decimator_with_sync_lookup_top.sv
// Top level of the trajectory decimator with sync lookup.
//
// Trajectory points and sync queries arrive one transaction at a time on the item channel,
// and each gives at most one transaction on the result channel. The first point of a
// trajectory is always kept and restarts the stored route; a later point is kept when its
// squared 3-D distance from the last kept point exceeds the keep distance squared (the final
// point also passes on the end distance). The distance work runs on a single 17 by 17 bit
// squarer shared under a small sequencer: the two thresholds and the three axis differences
// are squared in turn, each through the operand, multiply and accumulate states, while a
// first point skips the squarer and goes straight to the decision. A sync query walks the
// stored times through the route memory's single read port, one entry per cycle. The
// result sits in an output register, so a new transaction is accepted while an earlier result
// still waits; the block only stalls when a second result is finished before the first has
// been taken. The route memory needs no clearing after reset, since only entries already
// written are read.
module trajectory_decimator_with_sync_lookup_top #(
  parameter int ROUTE_DEPTH = tdsl_pkg::DEF_ROUTE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  tdsl_item_if.sink                           item,
  tdsl_result_if.source                       result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tdsl_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [tdsl_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [tdsl_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int CW     = tdsl_pkg::COORD_W;
  localparam int SW     = tdsl_pkg::SPEED_W;
  localparam int TW     = tdsl_pkg::TIME_W;
  localparam int DW     = tdsl_pkg::DIST_W;
  localparam int KW     = tdsl_pkg::CHUNK_W;
  localparam int SAT_W  = tdsl_pkg::SAT_W;
  localparam int SQ_W   = tdsl_pkg::SQ_W;
  localparam int D2_W   = tdsl_pkg::D2_W;
  localparam int IDX_W  = $clog2(ROUTE_DEPTH);
  localparam int CNT_W  = $clog2(ROUTE_DEPTH + 1);
  localparam int ADR_W  = tdsl_pkg::APB_ADDR_W;
  localparam int PDW    = tdsl_pkg::APB_DATA_W;

  // Saturated magnitude of the difference of two coordinates.
  function automatic logic [SAT_W-1:0] axis_mag(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    logic signed [CW:0] d;
    logic        [CW:0] m;
    d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    m = d[CW] ? $unsigned(-d) : $unsigned(d);
    axis_mag = (m > (CW+1)'(tdsl_pkg::AXIS_SAT)) ? tdsl_pkg::AXIS_SAT : m[SAT_W-1:0];
  endfunction

  function automatic logic [TW-1:0] time_gap(input logic [TW-1:0] a, input logic [TW-1:0] b);
    time_gap = (a >= b) ? (a - b) : (b - a);
  endfunction

  // Configuration registers.
  logic [DW-1:0] keep_dist;
  logic [DW-1:0] end_dist;
  logic [KW-1:0] chunk_size;

  // Sequencer.
  tdsl_pkg::state_t state, state_next;
  tdsl_pkg::step_t  step;

  // Route state.
  logic signed [CW-1:0] last_kept_x, last_kept_y, last_kept_z;
  logic [CNT_W-1:0]     stored_count;
  logic [KW-1:0]        chunk_fill;
  logic                 in_first_chunk;

  // The transaction being worked on.
  logic                 op_q;
  logic signed [CW-1:0] x_q, y_q, z_q;
  logic signed [SW-1:0] spd_q;
  logic [TW-1:0]        t_q;
  logic                 first_q, last_q;
  logic [TW-1:0]        qt_q;

  // Shared squarer and its accumulators.
  logic [SAT_W-1:0] opnd;
  logic [SQ_W-1:0]  sq;
  logic [DW*2-1:0]  k2, e2;
  logic [D2_W-1:0]  d2;

  // Route memory and the scan pipeline of a sync query.
  logic [TW-1:0]    route_times [ROUTE_DEPTH];
  logic [TW-1:0]    rd_data;
  logic [CNT_W-1:0] scan_idx;
  logic             rd_vld, dist_vld, best_set;
  logic [IDX_W-1:0] rd_idx, dist_idx, best_idx;
  logic [TW-1:0]    scan_gap, best_d;
  logic             scan_issue, scan_done;

  // Pending result, waiting for the output register.
  logic                         pend_vld;
  tdsl_pkg::kind_t              pend_kind;
  logic signed [CW-1:0]         pend_x, pend_y;
  logic signed [SW-1:0]         pend_spd;
  logic [TW-1:0]                pend_t;
  logic                         pend_end, pend_replace, pend_full;
  logic [tdsl_pkg::SYNC_W-1:0]  pend_sync;

  // Output register.
  logic                         out_valid;
  tdsl_pkg::kind_t              out_kind;
  logic signed [CW-1:0]         out_x, out_y;
  logic signed [SW-1:0]         out_spd;
  logic [TW-1:0]                out_t;
  logic                         out_end, out_replace, out_full;
  logic [tdsl_pkg::SYNC_W-1:0]  out_sync;

  // Decision of a trajectory point, valid in the decide state.
  logic [CNT_W-1:0] cnt_eff;
  logic [KW-1:0]    fill_eff;
  logic [KW:0]      fill_inc;
  logic             first_chunk_eff, keep, full_now, close, flush;
  logic             accept, slot_free, out_load, mem_we, cfg_we;

  assign accept    = item.valid && item.ready;
  assign slot_free = !out_valid || result.ready;
  assign cfg_we    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  // A first point restarts the route, so it sees an empty route and an open first chunk.
  assign cnt_eff         = first_q ? '0 : stored_count;
  assign fill_eff        = first_q ? '0 : chunk_fill;
  assign first_chunk_eff = first_q || in_first_chunk;
  assign keep     = first_q || (d2 > D2_W'(k2)) || (last_q && (d2 > D2_W'(e2)));
  assign full_now = (cnt_eff >= CNT_W'(ROUTE_DEPTH));
  assign fill_inc = {1'b0, fill_eff} + (KW+1)'(1);
  assign close    = last_q || (fill_inc >= {1'b0, chunk_size});
  assign flush    = last_q && (chunk_fill != '0);

  assign scan_done = (scan_idx == stored_count) && !rd_vld && !dist_vld;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      tdsl_pkg::ST_IDLE: begin
        if (item.valid) begin
          if (item.op == tdsl_pkg::OP_QUERY) begin
            state_next = tdsl_pkg::ST_SCAN;
          end else if (item.first_point) begin
            state_next = tdsl_pkg::ST_DECIDE;
          end else begin
            state_next = tdsl_pkg::ST_OPND;
          end
        end
      end
      tdsl_pkg::ST_OPND:   state_next = tdsl_pkg::ST_MUL;
      tdsl_pkg::ST_MUL:    state_next = tdsl_pkg::ST_ACC;
      tdsl_pkg::ST_ACC: begin
        state_next = (step == tdsl_pkg::STEP_DZ) ? tdsl_pkg::ST_DECIDE : tdsl_pkg::ST_OPND;
      end
      tdsl_pkg::ST_DECIDE: state_next = tdsl_pkg::ST_EMIT;
      tdsl_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = tdsl_pkg::ST_EMIT;
        end
      end
      tdsl_pkg::ST_EMIT: begin
        if (!pend_vld || slot_free) begin
          state_next = tdsl_pkg::ST_IDLE;
        end
      end
      default: state_next = tdsl_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    item.ready = 1'b0;
    mem_we     = 1'b0;
    scan_issue = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      tdsl_pkg::ST_IDLE:   item.ready = 1'b1;
      tdsl_pkg::ST_DECIDE: mem_we     = keep && !full_now;
      tdsl_pkg::ST_SCAN:   scan_issue = (scan_idx != stored_count);
      tdsl_pkg::ST_EMIT:   out_load   = pend_vld && slot_free;
      default: ;
    endcase
  end

  // Operand of the shared squarer for the current step.
  always_comb begin
    case (step)
      tdsl_pkg::STEP_KEEP: opnd = SAT_W'(keep_dist);
      tdsl_pkg::STEP_END:  opnd = SAT_W'(end_dist);
      tdsl_pkg::STEP_DX:   opnd = axis_mag(x_q, last_kept_x);
      tdsl_pkg::STEP_DY:   opnd = axis_mag(y_q, last_kept_y);
      tdsl_pkg::STEP_DZ:   opnd = axis_mag(z_q, last_kept_z);
      default:             opnd = '0;
    endcase
  end

  // Configuration read-back.
  always_comb begin
    unique case (tdsl_pkg::reg_idx_t'(paddr[3:2]))
      tdsl_pkg::REG_KEEP_DIST:  prdata = PDW'(keep_dist);
      tdsl_pkg::REG_END_DIST:   prdata = PDW'(end_dist);
      tdsl_pkg::REG_CHUNK_SIZE: prdata = PDW'(chunk_size);
      default:                  prdata = '0;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= tdsl_pkg::ST_IDLE;
      step           <= tdsl_pkg::STEP_KEEP;
      keep_dist      <= tdsl_pkg::KEEP_DIST_RESET;
      end_dist       <= tdsl_pkg::END_DIST_RESET;
      chunk_size     <= tdsl_pkg::CHUNK_SIZE_RESET;
      last_kept_x    <= '0;
      last_kept_y    <= '0;
      last_kept_z    <= '0;
      stored_count   <= '0;
      chunk_fill     <= '0;
      in_first_chunk <= 1'b1;
      scan_idx       <= '0;
      rd_vld         <= 1'b0;
      dist_vld       <= 1'b0;
      best_set       <= 1'b0;
      pend_vld       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (tdsl_pkg::reg_idx_t'(paddr[3:2]))
          tdsl_pkg::REG_KEEP_DIST:  keep_dist  <= pwdata[DW-1:0];
          tdsl_pkg::REG_END_DIST:   end_dist   <= pwdata[DW-1:0];
          tdsl_pkg::REG_CHUNK_SIZE: chunk_size <= pwdata[KW-1:0];
          default: ;
        endcase
      end

      if (accept) begin
        step     <= tdsl_pkg::STEP_KEEP;
        scan_idx <= '0;
        rd_vld   <= 1'b0;
        dist_vld <= 1'b0;
        best_set <= 1'b0;
      end

      if (state == tdsl_pkg::ST_ACC) begin
        case (step)
          tdsl_pkg::STEP_KEEP: step <= tdsl_pkg::STEP_END;
          tdsl_pkg::STEP_END:  step <= tdsl_pkg::STEP_DX;
          tdsl_pkg::STEP_DX:   step <= tdsl_pkg::STEP_DY;
          tdsl_pkg::STEP_DY:   step <= tdsl_pkg::STEP_DZ;
          default:             step <= tdsl_pkg::STEP_KEEP;
        endcase
      end

      if (state == tdsl_pkg::ST_DECIDE) begin
        pend_vld <= keep || flush;
        if (keep) begin
          last_kept_x    <= x_q;
          last_kept_y    <= y_q;
          last_kept_z    <= z_q;
          stored_count   <= full_now ? cnt_eff : (cnt_eff + CNT_W'(1));
          chunk_fill     <= close ? '0 : fill_inc[KW-1:0];
          in_first_chunk <= close ? 1'b0 : first_chunk_eff;
        end else if (flush) begin
          chunk_fill     <= '0;
          in_first_chunk <= 1'b0;
        end
      end

      if (state == tdsl_pkg::ST_SCAN) begin
        if (scan_issue) begin
          scan_idx <= scan_idx + CNT_W'(1);
        end
        rd_vld   <= scan_issue;
        dist_vld <= rd_vld;
        if (dist_vld && (!best_set || (scan_gap < best_d))) begin
          best_set <= 1'b1;
        end
        if (scan_done) begin
          pend_vld <= 1'b1;
        end
      end

      if ((state == tdsl_pkg::ST_EMIT) && (state_next == tdsl_pkg::ST_IDLE)) begin
        pend_vld <= 1'b0;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= item.op;
      x_q      <= item.x_mm;
      y_q      <= item.y_mm;
      z_q      <= item.z_mm;
      spd_q    <= item.speed_mm_s;
      t_q      <= item.time_ms;
      first_q  <= item.first_point;
      last_q   <= item.last_point;
      qt_q     <= item.query_time_ms;
      d2       <= '0;
      best_idx <= '0;
    end

    if (state == tdsl_pkg::ST_MUL) begin
      sq <= SQ_W'(opnd) * SQ_W'(opnd);
    end

    if (state == tdsl_pkg::ST_ACC) begin
      case (step)
        tdsl_pkg::STEP_KEEP: k2 <= sq[DW*2-1:0];
        tdsl_pkg::STEP_END:  e2 <= sq[DW*2-1:0];
        default:             d2 <= d2 + D2_W'(sq);
      endcase
    end

    if (state == tdsl_pkg::ST_DECIDE) begin
      pend_sync <= '0;
      if (keep) begin
        pend_kind    <= tdsl_pkg::KIND_POINT;
        pend_x       <= x_q;
        pend_y       <= y_q;
        pend_spd     <= spd_q;
        pend_t       <= t_q;
        pend_end     <= close;
        pend_replace <= close && first_chunk_eff;
        pend_full    <= full_now;
      end else begin
        pend_kind    <= tdsl_pkg::KIND_FLUSH;
        pend_x       <= '0;
        pend_y       <= '0;
        pend_spd     <= '0;
        pend_t       <= '0;
        pend_end     <= 1'b1;
        pend_replace <= in_first_chunk;
        pend_full    <= 1'b0;
      end
    end

    if (state == tdsl_pkg::ST_SCAN) begin
      rd_idx   <= scan_idx[IDX_W-1:0];
      scan_gap <= time_gap(rd_data, qt_q);
      dist_idx <= rd_idx;
      if (dist_vld && (!best_set || (scan_gap < best_d))) begin
        best_d   <= scan_gap;
        best_idx <= dist_idx;
      end
      if (scan_done) begin
        pend_kind    <= tdsl_pkg::KIND_SYNC;
        pend_x       <= '0;
        pend_y       <= '0;
        pend_spd     <= '0;
        pend_t       <= '0;
        pend_end     <= 1'b0;
        pend_replace <= 1'b0;
        pend_full    <= 1'b0;
        pend_sync    <= tdsl_pkg::SYNC_W'(best_idx);
      end
    end

    if (out_load) begin
      out_kind    <= pend_kind;
      out_x       <= pend_x;
      out_y       <= pend_y;
      out_spd     <= pend_spd;
      out_t       <= pend_t;
      out_end     <= pend_end;
      out_replace <= pend_replace;
      out_full    <= pend_full;
      out_sync    <= pend_sync;
    end
  end

  // Route memory: written with the kept time, read during a sync scan.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      route_times[cnt_eff[IDX_W-1:0]] <= t_q;
    end
    rd_data <= route_times[scan_idx[IDX_W-1:0]];
  end

  assign result.valid          = out_valid;
  assign result.kind           = out_kind;
  assign result.out_x_mm       = out_x;
  assign result.out_y_mm       = out_y;
  assign result.out_speed_mm_s = out_spd;
  assign result.out_time_ms    = out_t;
  assign result.chunk_end      = out_end;
  assign result.replace_route  = out_replace;
  assign result.route_full     = out_full;
  assign result.sync_index     = out_sync;

  // The route never holds more entries than the memory provides.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CNT_W'(ROUTE_DEPTH))
    else $error("stored route count beyond memory depth");

  // A sync answer always points at a stored entry of a non-empty route.
  a_sync_in_route: assert property (@(posedge clk) disable iff (rst)
    (out_load && (pend_kind == tdsl_pkg::KIND_SYNC) && (stored_count != '0))
      |-> (CNT_W'(best_idx) < stored_count))
    else $error("sync answer outside the stored route");

  // A route replacement is only ever signalled on a result that closes a chunk.
  a_replace_closes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_replace) |-> out_end)
    else $error("replace_route without chunk_end");

  // A sync query passes through the scan and never through the distance sequencer.
  a_query_path: assert property (@(posedge clk) disable iff (rst)
    (state == tdsl_pkg::ST_DECIDE) |-> (op_q != tdsl_pkg::OP_QUERY))
    else $error("sync query reached the point decision");

endmodule
